@@ rtl/distinct_key_top_k_table_core_macros.svh @@
// assertion macros for the distinct key top-k table core
`ifndef DISTINCT_KEY_TOP_K_TABLE_CORE_MACROS_SVH
`define DISTINCT_KEY_TOP_K_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// checked property, held off during reset
`define DKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked property, also during reset
`define DKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DKT_ASSERT(lbl, prop, msg)
`define DKT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/dktopk_pkg.sv @@
// ----------------------------------------------------------------------------
// dktopk_pkg
// sizes shared by the distinct key top-k table core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dktopk_pkg;
  localparam int TableEntries = 16;
  localparam int NameBytes    = 32;
  localparam int NameBits     = 256;
  localparam int StrW         = 8;
  localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW         = $clog2(TableEntries + 1);
endpackage
`default_nettype wire

@@ rtl/distinct_key_top_k_table_core.sv @@
// ----------------------------------------------------------------------------
// distinct_key_top_k_table_core
// folds scan records into a table of distinct names with best strength and
// emits the table strongest first on the last record of a batch
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o | name_word0..3, strength, last_record
// out     | output    | out_valid_o / out_stall_i | out_word0..3, out_strength, flags
//
// for a record, the scan does one name/strength memory read per stored
// entry for the match and weakest search, then at most one write. emission
// does a full strength scan of the memory per emitted word. reset clears
// control only; only memory entries below the fill count are compared.
// input stalls during all work, and a stalled output word holds the emission
// sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "distinct_key_top_k_table_core_macros.svh"
module distinct_key_top_k_table_core
  import dktopk_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [63:0]            name_word0_i,
  input  wire logic [63:0]            name_word1_i,
  input  wire logic [63:0]            name_word2_i,
  input  wire logic [63:0]            name_word3_i,
  input  wire logic signed [StrW-1:0] strength_i,
  input  wire logic                   last_record_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [63:0]                 out_word0_o,
  output logic [63:0]                 out_word1_o,
  output logic [63:0]                 out_word2_o,
  output logic [63:0]                 out_word3_o,
  output logic signed [StrW-1:0]      out_strength_o,
  output logic                        entry_valid_o,
  output logic                        last_entry_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_UPD, ST_SORT, ST_FETCH, ST_LOAD, ST_EMPTY
  } state_e;

  function automatic logic [NameBits-1:0] norm_name(input logic [NameBits-1:0] w);
    logic ended;
    logic [NameBits-1:0] r;
    ended = 1'b0;
    r = '0;
    for (int b = 0; b < NameBits / 8; b++) begin
      if (b >= NameBytes || w[b*8 +: 8] == 8'd0) ended = 1'b1;
      if (!ended) r[b*8 +: 8] = w[b*8 +: 8];
    end
    return r;
  endfunction

  localparam logic [CntW-1:0] Full = CntW'(TableEntries);

  state_e                 state_q;
  logic [NameBits-1:0]    name_q;
  logic signed [StrW-1:0] str_q;
  logic                   last_q, skip_q, batch_open_q;
  logic [CntW-1:0]        count_q, c_q, rank_q;
  logic                   cmp_vld_q;
  logic [IdxW-1:0]        cmp_idx_q;
  logic                   hit_q;
  logic [IdxW-1:0]        hit_idx_q, weak_idx_q, best_idx_q;
  logic signed [StrW-1:0] hit_str_q, weak_str_q, best_str_q;
  logic                   have_q;
  logic [TableEntries-1:0] emitted_q;

  logic                   out_valid_q, entry_valid_q, last_entry_q;
  logic [NameBits-1:0]    out_name_q;
  logic signed [StrW-1:0] out_str_q;
  logic                   out_load, emitting;

  // table memories
  logic [NameBits-1:0]    name_mem [TableEntries];
  logic signed [StrW-1:0] str_mem  [TableEntries];
  logic [NameBits-1:0]    name_rd_q;
  logic signed [StrW-1:0] str_rd_q;
  logic [IdxW-1:0]        rd_addr, wr_addr, str_wr_addr;
  logic                   name_we, str_we, take_free, upd;

  assign upd       = (state_q == ST_UPD) && !skip_q;
  assign take_free = upd && !hit_q && (count_q < Full);
  assign name_we   = take_free || (upd && !hit_q && (count_q == Full) && (str_q > weak_str_q));
  assign wr_addr   = take_free ? count_q[IdxW-1:0] : weak_idx_q;
  assign str_we    = name_we || (upd && hit_q && (str_q > hit_str_q));
  assign str_wr_addr = hit_q ? hit_idx_q : wr_addr;
  // hold the chosen slot on the read port while the word waits to load
  assign rd_addr   = (state_q == ST_FETCH || state_q == ST_LOAD) ? best_idx_q
                                                                 : c_q[IdxW-1:0];
  assign out_load  = (state_q == ST_LOAD || state_q == ST_EMPTY) &&
                     (!out_valid_q || !out_stall_i);
  assign emitting  = (state_q == ST_SORT || state_q == ST_FETCH || state_q == ST_LOAD);

  always_ff @(posedge clk_i) begin
    if (name_we) name_mem[wr_addr] <= name_q;
    if (str_we)  str_mem[str_wr_addr] <= str_q;
    name_rd_q <= name_mem[rd_addr];
    str_rd_q  <= str_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      batch_open_q <= 1'b0;
      count_q      <= '0;
      c_q          <= '0;
      rank_q       <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      have_q       <= 1'b0;
      emitted_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            name_q       <= norm_name({name_word3_i, name_word2_i, name_word1_i, name_word0_i});
            str_q        <= strength_i;
            last_q       <= last_record_i;
            skip_q       <= (name_word0_i[7:0] == 8'd0);
            count_q      <= batch_open_q ? count_q : '0;
            batch_open_q <= 1'b1;
            c_q          <= '0;
            cmp_vld_q    <= 1'b0;
            hit_q        <= 1'b0;
            state_q      <= (name_word0_i[7:0] == 8'd0) ? ST_UPD : ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= (c_q < count_q);
          cmp_idx_q <= c_q[IdxW-1:0];
          if (c_q < count_q) c_q <= c_q + 1'b1;
          if (cmp_vld_q && name_rd_q == name_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cmp_idx_q;
            hit_str_q <= str_rd_q;
            state_q   <= ST_UPD;
          end else begin
            // weakest slot, lowest index on ties
            if (cmp_vld_q && (cmp_idx_q == '0 || str_rd_q < weak_str_q)) begin
              weak_idx_q <= cmp_idx_q;
              weak_str_q <= str_rd_q;
            end
            if (c_q == count_q && !cmp_vld_q) state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (take_free) count_q <= count_q + 1'b1;
          c_q       <= '0;
          cmp_vld_q <= 1'b0;
          have_q    <= 1'b0;
          rank_q    <= '0;
          emitted_q <= '0;
          if (!last_q) state_q <= ST_IDLE;
          else if (count_q == '0 && !take_free) state_q <= ST_EMPTY;
          else state_q <= ST_SORT;
        end
        ST_SORT: begin
          cmp_vld_q <= (c_q < count_q);
          cmp_idx_q <= c_q[IdxW-1:0];
          if (c_q < count_q) c_q <= c_q + 1'b1;
          // strongest not yet emitted, first slot wins ties
          if (cmp_vld_q && !emitted_q[cmp_idx_q] && (!have_q || str_rd_q > best_str_q)) begin
            have_q     <= 1'b1;
            best_idx_q <= cmp_idx_q;
            best_str_q <= str_rd_q;
          end
          if (c_q == count_q && !cmp_vld_q) state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            out_name_q    <= name_rd_q;
            out_str_q     <= str_rd_q;
            entry_valid_q <= 1'b1;
            last_entry_q  <= (rank_q + 1'b1 == count_q);
            emitted_q[best_idx_q] <= 1'b1;
            rank_q        <= rank_q + 1'b1;
            c_q           <= '0;
            cmp_vld_q     <= 1'b0;
            have_q        <= 1'b0;
            if (rank_q + 1'b1 == count_q) begin
              batch_open_q <= 1'b0;
              state_q      <= ST_IDLE;
            end else begin
              state_q <= ST_SORT;
            end
          end
        end
        ST_EMPTY: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            out_name_q    <= '0;
            out_str_q     <= '0;
            entry_valid_q <= 1'b0;
            last_entry_q  <= 1'b1;
            batch_open_q  <= 1'b0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_word0_o    = out_name_q[63:0];
  assign out_word1_o    = out_name_q[127:64];
  assign out_word2_o    = out_name_q[191:128];
  assign out_word3_o    = out_name_q[255:192];
  assign out_strength_o = out_str_q;
  assign entry_valid_o  = entry_valid_q;
  assign last_entry_o   = last_entry_q;

  `DKT_ASSERT(a_count_range, count_q <= Full, "fill count beyond table size")
  `DKT_ASSERT(a_emit_count, emitting |-> ($countones(emitted_q) == int'(rank_q)), "emit flags vs rank")
  `DKT_ASSERT(a_load_src, $rose(out_valid_q) |-> ($past(state_q) == ST_LOAD || $past(state_q) == ST_EMPTY), "stray output load")
  `DKT_ASSERT(a_batch_close, (last_entry_q && $rose(out_valid_q)) |-> !batch_open_q, "batch open after last word")

endmodule
`default_nettype wire

@@ bench/distinct_key_top_k_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// distinct_key_top_k_table_core_tb
// self-checking bench: scan record batches are folded into a local copy of the
// name table; on each last record the expected emission order is queued and
// every output word is compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module distinct_key_top_k_table_core_tb;
  import dktopk_pkg::*;

  typedef struct packed {
    logic [63:0]     w0, w1, w2, w3;
    logic [StrW-1:0] str;
    logic            valid;
    logic            last;
  } entry_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [63:0] name_word0_i = '0, name_word1_i = '0, name_word2_i = '0, name_word3_i = '0;
  logic signed [StrW-1:0] strength_i = '0;
  logic last_record_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [63:0] out_word0_o, out_word1_o, out_word2_o, out_word3_o;
  logic signed [StrW-1:0] out_strength_o;
  logic entry_valid_o, last_entry_o;

  distinct_key_top_k_table_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the table
  logic [NameBits-1:0] tbl_name [TableEntries];
  int                  tbl_str  [TableEntries];
  int                  tbl_fill;
  bit                  tbl_open;
  entry_word_t         sorted_q[$];

  int  mismatches, words_seen, batches, cycles;
  bit  idle_en = 1'b0;
  bit  hold_out = 1'b0;
  int  hold_cycles = 0;
  logic [63:0] pool [8][4];

  function automatic logic [NameBits-1:0] clean_name(logic [NameBits-1:0] raw);
    logic [NameBits-1:0] r;
    bit ended;
    r = '0;
    ended = 1'b0;
    for (int b = 0; b < NameBits / 8; b++) begin
      if (b >= NameBytes || raw[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[b*8 +: 8] = raw[b*8 +: 8];
    end
    return r;
  endfunction

  task automatic fold_record(logic [NameBits-1:0] raw, int s, bit last);
    logic [NameBits-1:0] nm;
    int weakest, n, key, j;
    int order [TableEntries];
    bit found;
    entry_word_t e;
    if (!tbl_open) begin
      tbl_fill = 0;
      tbl_open = 1'b1;
    end
    nm = clean_name(raw);
    found = 1'b0;
    if (nm[7:0] != 8'h00) begin
      for (int i = 0; i < tbl_fill && !found; i++)
        if (tbl_name[i] == nm) begin
          found = 1'b1;
          if (s > tbl_str[i]) tbl_str[i] = s;
        end
      if (!found) begin
        if (tbl_fill < TableEntries) begin
          tbl_name[tbl_fill] = nm;
          tbl_str[tbl_fill] = s;
          tbl_fill++;
        end else begin
          weakest = 0;
          for (int i = 1; i < tbl_fill; i++)
            if (tbl_str[i] < tbl_str[weakest]) weakest = i;
          if (s > tbl_str[weakest]) begin
            tbl_name[weakest] = nm;
            tbl_str[weakest] = s;
          end
        end
      end
    end
    if (!last) return;
    tbl_open = 1'b0;
    batches++;
    n = tbl_fill;
    if (n == 0) begin
      e = '0;
      e.last = 1'b1;
      sorted_q.push_back(e);
      return;
    end
    for (int i = 0; i < n; i++) begin
      key = i;
      j = i;
      while (j > 0 && tbl_str[order[j-1]] < tbl_str[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    for (int i = 0; i < n; i++) begin
      e.w0 = tbl_name[order[i]][63:0];
      e.w1 = tbl_name[order[i]][127:64];
      e.w2 = tbl_name[order[i]][191:128];
      e.w3 = tbl_name[order[i]][255:192];
      e.str = tbl_str[order[i]][StrW-1:0];
      e.valid = 1'b1;
      e.last = (i == n - 1);
      sorted_q.push_back(e);
    end
  endtask

  // valid stays up between back to back words; idle gaps drop it
  task automatic send_record(logic [NameBits-1:0] raw, logic [7:0] s, bit last);
    while (idle_en && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {name_word3_i, name_word2_i, name_word1_i, name_word0_i} <= raw;
    strength_i <= s;
    last_record_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_record(raw, $signed(s), last);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [NameBits-1:0] str_name(string t);
    logic [NameBits-1:0] r = '0;
    for (int i = 0; i < t.len() && i < 32; i++) r[i*8 +: 8] = t[i];
    return r;
  endfunction

  function automatic logic [NameBits-1:0] rand_name();
    logic [NameBits-1:0] r;
    int len;
    case ($urandom_range(9))
      0: return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
      1: return '1;
      2: return '0;
      default: begin
        // pick from a small pool so names repeat; sometimes trail junk
        r = {pool[$urandom_range(7)][3], pool[$urandom_range(7)][2],
             pool[$urandom_range(7)][1], pool[$urandom_range(7)][0]};
        r = {pool[$urandom_range(7)][3], pool[$urandom_range(7)][2],
             pool[$urandom_range(7)][1], pool[$urandom_range(7)][0]};
        len = $urandom_range(1, 32);
        if (len < 32) r[len*8 +: 8] = 8'h00;
        return r;
      end
    endcase
  endfunction

  task automatic test_directed();
    send_record('0, 8'sd5, 1'b1);                     // empty table
    send_record(str_name("ap1"), 8'h80, 1'b0);
    send_record(str_name("ap1"), 8'h7f, 1'b0);        // known name rises
    send_record(str_name("ap1"), 8'h00, 1'b0);        // known name kept
    send_record({8'hee, 240'h0, 8'h00}, 8'h7f, 1'b0); // empty, junk after zero
    send_record({{24{8'hff}}, 64'h00ff_ffff_ffff_ffff}, 8'hff, 1'b0);
    send_record({{24{8'hff}}, 64'h44ff_ffff_ffff_ffff}, 8'h01, 1'b0);
    send_record('1, 8'sd1, 1'b0);
    send_record(str_name("tie"), 8'sd1, 1'b1);
    send_record('0, 8'sd0, 1'b1);                      // empty last record
    for (int i = 0; i < 16; i++)
      send_record(str_name($sformatf("n%0d", i)), 8'(i % 4), 1'b0);
    send_record(str_name("weak"), 8'sd0, 1'b0);        // not strictly stronger
    send_record(str_name("big"), 8'sd1, 1'b0);         // replaces lowest weakest
    send_record(str_name("fresh"), 8'sd9, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_batches(int count);
    bit last;
    for (int i = 0; i < count; i++) begin
      last = ($urandom_range(99) < 6);
      send_record(rand_name(), 8'($urandom), last);
    end
    send_record(rand_name(), 8'($urandom), 1'b1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    hold_out = 1'b1;
    for (int i = 0; i < 20; i++) send_record(rand_name(), 8'($urandom), (i % 6) == 5);
    send_record(rand_name(), 8'($urandom), 1'b1);
    wait_drained();
  endtask

  // output side stall pattern, with a long hold when requested
  always @(posedge clk_i) begin
    if (hold_out && hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
      if (hold_cycles == 1) hold_out <= 1'b0;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99) < 8);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    entry_word_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      got = {out_word0_o, out_word1_o, out_word2_o, out_word3_o, out_strength_o,
             entry_valid_o, last_entry_o};
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %p", got);
      end else begin
        want = sorted_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    words_seen = 0;
    batches = 0;
    cycles = 0;
    tbl_fill = 0;
    tbl_open = 1'b0;
    for (int i = 0; i < 8; i++)
      for (int k = 0; k < 4; k++) pool[i][k] = {$urandom, $urandom} | 64'h0101_0101_0101_0101;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_batches(100);       // no idling stretch
    idle_en = 1'b1;
    test_random_batches(170);
    wait_drained();                 // sender pauses until all words are back
    test_backpressure();
    test_random_batches(50);
    wait_drained();
    repeat (400) @(posedge clk_i);
    $display("covered %0d batches, %0d output words, with stalls on both sides",
             batches, words_seen);
    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, sorted_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
